// ===== rtl/core/kalman_angle_bias_filter_top_assert.svh =====
// Assertion macros for the angle/bias filter checker.
`ifndef KALMAN_ANGLE_BIAS_FILTER_TOP_ASSERT_SVH
`define KALMAN_ANGLE_BIAS_FILTER_TOP_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define KABF_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define KABF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== rtl/core/kabf_pkg.sv =====
// Shared widths, codes and saturation helpers for the angle/bias filter.
package kabf_pkg;
  localparam int DataWidth = 32;
  localparam int FracBits = 22;
  localparam int UWidth = DataWidth - 1;
  localparam int ProdWidth = 2 * DataWidth;
  localparam int DivSteps = DataWidth + FracBits;
  localparam int StepWidth = $clog2(DivSteps + 1);

  typedef logic signed [DataWidth-1:0] word_t;

  localparam logic [1:0] RegQValue = 2'd0;
  localparam logic [1:0] RegQBias = 2'd1;
  localparam logic [1:0] RegRMeasure = 2'd2;

  localparam logic [UWidth-1:0] QValueReset = UWidth'(4194);
  localparam logic [UWidth-1:0] QBiasReset = UWidth'(12583);
  localparam logic [UWidth-1:0] RMeasureReset = UWidth'(125829);

  localparam word_t WordMax = {1'b0, {(DataWidth-1){1'b1}}};
  localparam word_t WordMin = {1'b1, {(DataWidth-1){1'b0}}};

  // Operations of the shared unit.
  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2
  } alu_op_t;

  // Saturate a sum that is one bit wider than a word.
  function automatic word_t sat_wide(input logic signed [DataWidth:0] x);
    if (x[DataWidth] != x[DataWidth-1]) begin
      return x[DataWidth] ? WordMin : WordMax;
    end
    return x[DataWidth-1:0];
  endfunction

  // Apply sign to a magnitude, saturating.
  function automatic word_t signed_sat(input logic [ProdWidth-1:0] m, input logic neg,
                                       input logic ovf);
    logic [ProdWidth-1:0] lim;
    lim = ProdWidth'(WordMax);
    if (neg) begin
      if (ovf || m > lim + ProdWidth'(1)) return WordMin;
      return word_t'(~m[DataWidth-1:0] + DataWidth'(1));
    end
    if (ovf || m > lim) return WordMax;
    return m[DataWidth-1:0];
  endfunction
endpackage

// ===== rtl/core/kabf_divider.sv =====
// Restoring serial divider: fixed-point quotient truncated toward zero, saturated.
module kabf_divider (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  kabf_pkg::word_t       num,
  input  kabf_pkg::word_t       den,
  output logic                  done,
  output kabf_pkg::word_t       quot
);
  localparam int NW = kabf_pkg::DivSteps;
  logic                              busy;
  logic [kabf_pkg::StepWidth-1:0]    cnt;
  logic [NW-1:0]                     dividend;
  logic [kabf_pkg::DataWidth:0]      rem;
  logic [kabf_pkg::DataWidth-1:0]    dmag;
  logic [NW-1:0]                     q;
  logic                              neg;
  logic                              zero;
  logic [kabf_pkg::DataWidth:0]      trial;
  logic [kabf_pkg::DataWidth:0]      diff;
  logic [kabf_pkg::DataWidth-1:0]    nmag;
  logic                              ovf;

  assign nmag = num[kabf_pkg::DataWidth-1] ? (~num + 1'b1) : num;
  assign trial = {rem[kabf_pkg::DataWidth-1:0], dividend[NW-1]};
  assign diff = trial - {1'b0, dmag};
  // Quotient bits at or above bit 63 cannot occur for these widths, so ovf is tied
  // low; signed_sat still saturates any quotient beyond the signed word range.
  assign ovf = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
        dividend <= {nmag, {kabf_pkg::FracBits{1'b0}}};
        dmag <= den[kabf_pkg::DataWidth-1] ? (~den + 1'b1) : den;
        rem <= '0;
        q <= '0;
        neg <= num[kabf_pkg::DataWidth-1] ^ den[kabf_pkg::DataWidth-1];
        zero <= (den == '0);
      end else if (busy) begin
        dividend <= {dividend[NW-2:0], 1'b0};
        if (!diff[kabf_pkg::DataWidth]) begin
          rem <= diff;
          q <= {q[NW-2:0], 1'b1};
        end else begin
          rem <= trial;
          q <= {q[NW-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == kabf_pkg::StepWidth'(NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quot = zero ? '0 : kabf_pkg::signed_sat(kabf_pkg::ProdWidth'(q), neg, ovf);
endmodule

// ===== rtl/core/kalman_angle_bias_filter_top.sv =====
// Top level of the two-state angle/bias Kalman filter.
// Usage:
//  - s_axis carries one input transaction per filter item; tuser = mode
//    (0 update step, 1 load estimate), tdata = {dt, rate_in, measured}.
//  - m_axis returns one result transaction per item, tdata = {rate_corrected,
//    estimate}.
//  - cfg writes q_value (0), q_bias (1), meas_noise (2); always ready. Write
//    only while no item is in flight; the block itself does not enforce it.
// Timing:
//  - A set item goes from idle to the output step, which loads the output
//    register; the next item is taken once the sequencer is idle again.
//  - An update item runs 27 steps through one shared saturating
//    add/subtract/multiply unit plus two serial divides (start, 54-bit
//    quotient, hand-off), then loads the output register at its output step;
//    the next item is taken only once the sequencer is idle again.
//  - s_axis_tready is high only while the sequencer is idle.
// Reset: synchronous rst clears estimates, covariance, registers to defaults.
// Stall: a held result sits in the output register; the sequencer still takes
// and runs the next item, then waits at its output step until the register is
// free, so a stalled receiver stops intake after one more item.
module kalman_angle_bias_filter_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [95:0]  s_axis_tdata,  // measured[31:0], rate_in[63:32], dt[94:64], pad
  input  logic         s_axis_tuser,  // mode
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [63:0]  m_axis_tdata,  // estimate[31:0], rate_corrected[63:32]
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [30:0]  cfg_data
);
  localparam int DW = kabf_pkg::DataWidth;
  localparam int FB = kabf_pkg::FracBits;
  typedef logic signed [DW-1:0] w_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_ALU  = 4'b0010,
    S_DIV  = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t state;
  logic [4:0] step;
  logic [kabf_pkg::UWidth-1:0] q_value, q_bias, meas_noise;
  w_t value_est, bias_est, cov_00, cov_01, cov_10, cov_11;
  w_t meas, rate, dt, inner, y, s, k0, k1, p00, p01, t;
  logic div_start, div_done, div_sel;
  w_t div_quot;

  // Shared unit.
  kabf_pkg::alu_op_t op;
  w_t opa, opb, res;
  logic signed [2*DW-1:0] prod;
  logic [2*DW-1:0] pmag, prnd;
  always_comb begin
    prod = opa * opb;
    pmag = prod[2*DW-1] ? (~prod + 1'b1) : prod;
    prnd = pmag + (64'(1) << (FB - 1));
    case (op)
      kabf_pkg::OP_ADD: res = kabf_pkg::sat_wide({opa[DW-1], opa} + {opb[DW-1], opb});
      kabf_pkg::OP_SUB: res = kabf_pkg::sat_wide({opa[DW-1], opa} - {opb[DW-1], opb});
      default: res = kabf_pkg::signed_sat(prnd >> FB, prod[2*DW-1], 1'b0);
    endcase
  end

  kabf_divider u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .num(div_sel ? cov_10 : cov_00), .den(s),
    .done(div_done), .quot(div_quot)
  );

  w_t qv, qb, rm;
  assign qv = w_t'({1'b0, q_value});
  assign qb = w_t'({1'b0, q_bias});
  assign rm = w_t'({1'b0, meas_noise});

  // Step program: operands per step.
  always_comb begin
    op = kabf_pkg::OP_MUL; opa = dt; opb = rate;
    case (step)
      5'd0:  begin op = kabf_pkg::OP_MUL; opa = dt; opb = rate; end
      5'd1:  begin op = kabf_pkg::OP_ADD; opa = value_est; opb = t; end
      5'd2:  begin op = kabf_pkg::OP_MUL; opa = dt; opb = cov_11; end
      5'd3:  begin op = kabf_pkg::OP_SUB; opa = t; opb = cov_01; end
      5'd4:  begin op = kabf_pkg::OP_SUB; opa = inner; opb = cov_10; end
      5'd5:  begin op = kabf_pkg::OP_ADD; opa = inner; opb = qv; end
      5'd6:  begin op = kabf_pkg::OP_MUL; opa = dt; opb = inner; end
      5'd7:  begin op = kabf_pkg::OP_ADD; opa = cov_00; opb = t; end
      5'd8:  begin op = kabf_pkg::OP_MUL; opa = dt; opb = cov_11; end
      5'd9:  begin op = kabf_pkg::OP_SUB; opa = cov_01; opb = t; end
      5'd10: begin op = kabf_pkg::OP_SUB; opa = cov_10; opb = t; end
      5'd11: begin op = kabf_pkg::OP_MUL; opa = qb; opb = dt; end
      5'd12: begin op = kabf_pkg::OP_ADD; opa = cov_11; opb = t; end
      5'd13: begin op = kabf_pkg::OP_SUB; opa = meas; opb = value_est; end
      5'd14: begin op = kabf_pkg::OP_ADD; opa = cov_00; opb = rm; end
      5'd15: begin op = kabf_pkg::OP_MUL; opa = k0; opb = y; end
      5'd16: begin op = kabf_pkg::OP_ADD; opa = value_est; opb = t; end
      5'd17: begin op = kabf_pkg::OP_MUL; opa = k1; opb = y; end
      5'd18: begin op = kabf_pkg::OP_ADD; opa = bias_est; opb = t; end
      5'd19: begin op = kabf_pkg::OP_MUL; opa = k0; opb = p00; end
      5'd20: begin op = kabf_pkg::OP_SUB; opa = cov_00; opb = t; end
      5'd21: begin op = kabf_pkg::OP_MUL; opa = k0; opb = p01; end
      5'd22: begin op = kabf_pkg::OP_SUB; opa = cov_01; opb = t; end
      5'd23: begin op = kabf_pkg::OP_MUL; opa = k1; opb = p00; end
      5'd24: begin op = kabf_pkg::OP_SUB; opa = cov_10; opb = t; end
      5'd25: begin op = kabf_pkg::OP_MUL; opa = k1; opb = p01; end
      5'd26: begin op = kabf_pkg::OP_SUB; opa = cov_11; opb = t; end
      default: begin op = kabf_pkg::OP_SUB; opa = w_t'(s_axis_tdata[63:32]); opb = bias_est; end
    endcase
  end

  logic in_fire;
  logic out_load;
  assign cfg_ready = 1'b1;
  assign s_axis_tready = (state == S_IDLE);
  assign in_fire = s_axis_tvalid && s_axis_tready;
  // Output register takes a new result when empty or being taken.
  assign out_load = (state == S_OUT) && (!m_axis_tvalid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step <= 5'd31;
      m_axis_tvalid <= 1'b0;
      div_start <= 1'b0;
      div_sel <= 1'b0;
      q_value <= kabf_pkg::QValueReset;
      q_bias <= kabf_pkg::QBiasReset;
      meas_noise <= kabf_pkg::RMeasureReset;
      value_est <= '0; bias_est <= '0;
      cov_00 <= '0; cov_01 <= '0; cov_10 <= '0; cov_11 <= '0;
    end else begin
      div_start <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          kabf_pkg::RegQValue:   q_value <= cfg_data;
          kabf_pkg::RegQBias:    q_bias <= cfg_data;
          kabf_pkg::RegRMeasure: meas_noise <= cfg_data;
          default: ;
        endcase
      end
      if (out_load) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: if (in_fire) begin
          // step index 31 selects rate_in - bias_est on the shared unit
          meas <= w_t'(s_axis_tdata[31:0]);
          dt <= w_t'({1'b0, s_axis_tdata[94:64]});
          rate <= res;
          step <= '0;
          state <= s_axis_tuser ? S_OUT : S_ALU;
          if (s_axis_tuser) value_est <= w_t'(s_axis_tdata[31:0]);
        end
        S_ALU: begin
          // products stay in t until their add/subtract step
          if (op == kabf_pkg::OP_MUL) t <= res;
          case (step) inside
            5'd1, 5'd16: value_est <= res;
            5'd3, 5'd4, 5'd5: inner <= res;
            5'd7: cov_00 <= res;
            5'd9: cov_01 <= res;
            5'd10: cov_10 <= res;
            5'd12: cov_11 <= res;
            5'd13: y <= res;
            5'd14: s <= res;
            5'd18: bias_est <= res;
            5'd20: cov_00 <= res;
            5'd22: cov_01 <= res;
            5'd24: cov_10 <= res;
            5'd26: cov_11 <= res;
            default: ;
          endcase
          if (step == 5'd14) begin
            state <= S_DIV; div_sel <= 1'b0; div_start <= 1'b1;
            p00 <= cov_00; p01 <= cov_01;
            step <= step + 1'b1;
          end else if (step == 5'd26) begin
            state <= S_OUT;
            step <= 5'd31;
          end else begin
            step <= step + 1'b1;
          end
        end
        S_DIV: if (div_done) begin
          if (!div_sel) begin
            k0 <= div_quot; div_sel <= 1'b1; div_start <= 1'b1;
          end else begin
            k1 <= div_quot; state <= S_ALU;
          end
        end
        S_OUT: if (out_load) begin
          m_axis_tdata <= {rate, value_est};
          step <= 5'd31;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== rtl/core/kabf_checker.sv =====
// Port-level checker for the angle/bias filter, bound to the top level.
`include "kalman_angle_bias_filter_top_assert.svh"
module kabf_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata
);
  `KABF_ASSERT_NEXT(a_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result dropped or changed while stalled")
  `KABF_ASSERT_NEXT(a_busy, clk, rst, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken twice in a row")
  `KABF_ASSERT_IMPL(a_known, clk, rst, 1'b1, !$isunknown(s_axis_tready) && !$isunknown(m_axis_tvalid), "handshake output unknown")
endmodule

bind kalman_angle_bias_filter_top kabf_checker u_kabf_checker (
  .clk(clk), .rst(rst), .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
